// ===== rtl/core/clcg_pkg.sv =====
// ----------------------------------------------------------------------------
// clcg_pkg: shared types and constants for the combined LCG core
// Multipliers, moduli, fold constants, register indexes, sequencer states
// and the control word handed to the shared arithmetic unit.
// ----------------------------------------------------------------------------
package clcg_pkg;

	localparam int GEN_W  = 31;
	localparam int MULK_W = 16;
	localparam int PROD_W = GEN_W + MULK_W;
	localparam int DIF_W  = 8;
	localparam int HD_W   = MULK_W + DIF_W;
	localparam int FOLD_W = GEN_W + 1;

	// generator one: 40014 * s mod (2^31 - 85)
	localparam logic [MULK_W-1:0] MUL_ONE = 16'd40014;
	localparam logic [GEN_W-1:0]  MOD_ONE = 31'd2147483563;
	localparam logic [DIF_W-1:0]  DIF_ONE = 8'd85;

	// generator two: 40692 * s mod (2^31 - 249)
	localparam logic [MULK_W-1:0] MUL_TWO = 16'd40692;
	localparam logic [GEN_W-1:0]  MOD_TWO = 31'd2147483399;
	localparam logic [DIF_W-1:0]  DIF_TWO = 8'd249;

	localparam logic [GEN_W-1:0] WRAP_ADD   = 31'd2147483562;
	localparam logic [GEN_W-1:0] SEED_RESET = 31'd1;

	// configuration register indexes
	localparam logic REG_SEED_ONE = 1'b0;
	localparam logic REG_SEED_TWO = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL_A = 6'b000010,
		ST_MUL_B = 6'b000100,
		ST_RED_A = 6'b001000,
		ST_RED_B = 6'b010000,
		ST_MIX   = 6'b100000
	} clcg_state_t;

	// operand selects for the shared unit (1 = generator two)
	typedef struct packed {
		logic mul_two;
		logic fold_two;
		logic sub_two;
	} clcg_ctl_t;

endpackage

// ===== rtl/core/clcg_alu.sv =====
// ----------------------------------------------------------------------------
// clcg_alu: shared multiply and modular reduction unit
// 31x16 constant multiply, high-part fold (2^31 = d mod m) and a final
// conditional subtract, with constants picked per generator.
// ----------------------------------------------------------------------------
module clcg_alu
	import clcg_pkg::*;
(
	input  clcg_ctl_t         ctl,
	input  logic [GEN_W-1:0]  mul_src,
	input  logic [PROD_W-1:0] prod,
	input  logic [FOLD_W-1:0] fold,
	output logic [PROD_W-1:0] product,
	output logic [FOLD_W-1:0] folded,
	output logic [GEN_W-1:0]  reduced
);

	logic [MULK_W-1:0] mul_k;
	logic [DIF_W-1:0]  dif_k;
	logic [GEN_W-1:0]  mod_k;
	logic [MULK_W-1:0] prod_hi;
	logic [HD_W-1:0]   hi_term;
	logic [FOLD_W-1:0] fold_sub;

	// constant selection
	assign mul_k = ctl.mul_two  ? MUL_TWO : MUL_ONE;
	assign dif_k = ctl.fold_two ? DIF_TWO : DIF_ONE;
	assign mod_k = ctl.sub_two  ? MOD_TWO : MOD_ONE;

	// multiply
	assign product = {{MULK_W{1'b0}}, mul_src} * {{GEN_W{1'b0}}, mul_k};

	// fold: hi * 2^31 + lo == hi * d + lo (mod m), result below 2m
	assign prod_hi = prod[PROD_W-1:GEN_W];
	assign hi_term = {{DIF_W{1'b0}}, prod_hi} * {{MULK_W{1'b0}}, dif_k};
	assign folded  = {1'b0, prod[GEN_W-1:0]} + {{(FOLD_W-HD_W){1'b0}}, hi_term};

	// final conditional subtract
	assign fold_sub = fold - {1'b0, mod_k};
	assign reduced  = (fold >= {1'b0, mod_k}) ? fold_sub[GEN_W-1:0] : fold[GEN_W-1:0];

endmodule

// ===== rtl/core/combined_lcg_two_stream_31bit_core.sv =====
// ----------------------------------------------------------------------------
// combined_lcg_two_stream_31bit_core: two-generator combined LCG source
// Advances two 31-bit multiplicative generators per request and returns
// their wrapped difference as a 31-bit value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word: restart. With
//   restart set, both generators load seed_one/seed_two before advancing.
//   Output channel (out_valid/out_ready) carries random_value, 1..2147483562.
//   Seeds are written on cfg_we with cfg_index 0 (seed_one) or 1 (seed_two);
//   the user must write them only while the core is idle; the core does not enforce it.
// Sequence:
//   An accepted word steps through MUL_A, MUL_B, RED_A, RED_B and MIX;
//   out_valid rises when MIX passes the value to the output register.
//   A new word can be accepted as the previous one leaves MIX. The single
//   multiplier and reduction unit is used twice per word (once per generator), then MIX combines.
// Reset:
//   Both generators and both seeds reset to 1; no value is pending.
// Stall:
//   The finished value sits in the output register; a following word is
//   still taken and holds in its combine step until the register frees.
// ----------------------------------------------------------------------------
module combined_lcg_two_stream_31bit_core
	import clcg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [GEN_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             restart,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [GEN_W-1:0] random_value
);

	clcg_state_t       st_q;
	logic [GEN_W-1:0]  seed_one_q, seed_two_q;
	logic [GEN_W-1:0]  gen_one_q, gen_two_q;
	logic [PROD_W-1:0] prod_q;
	logic [FOLD_W-1:0] fold_q;
	logic [GEN_W-1:0]  value_q;
	logic              out_valid_q;

	clcg_ctl_t         ctl;
	logic [GEN_W-1:0]  mul_src;
	logic [PROD_W-1:0] product;
	logic [FOLD_W-1:0] folded;
	logic [GEN_W-1:0]  reduced;
	logic              out_free;
	logic              in_acc;
	logic              mix_go;
	logic [GEN_W-1:0]  mix_diff;
	logic [GEN_W-1:0]  mix_val;

	assign out_free = !out_valid_q || out_ready;
	assign mix_go   = (st_q == ST_MIX) && out_free;
	assign in_ready = (st_q == ST_IDLE) || mix_go;
	assign in_acc   = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_one_q <= SEED_RESET;
			seed_two_q <= SEED_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_SEED_ONE) seed_one_q <= cfg_wdata;
			else seed_two_q <= cfg_wdata;
		end
	end

	// unit control per step
	always_comb begin
		ctl     = '0;
		mul_src = gen_one_q;
		case (st_q)
			ST_MUL_B: begin
				ctl.mul_two = 1'b1;
				mul_src     = gen_two_q;
			end
			ST_RED_A: begin
				ctl.fold_two = 1'b1;
			end
			ST_RED_B: begin
				ctl.sub_two = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	clcg_alu u_alu (
		.ctl     (ctl),
		.mul_src (mul_src),
		.prod    (prod_q),
		.fold    (fold_q),
		.product (product),
		.folded  (folded),
		.reduced (reduced)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE:  if (in_acc) st_q <= ST_MUL_A;
				ST_MUL_A: st_q <= ST_MUL_B;
				ST_MUL_B: st_q <= ST_RED_A;
				ST_RED_A: st_q <= ST_RED_B;
				ST_RED_B: st_q <= ST_MIX;
				ST_MIX: begin
					if (in_acc) st_q <= ST_MUL_A;
					else if (mix_go) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// generator state: seed load on restart, reduced value written back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_one_q <= SEED_RESET;
			gen_two_q <= SEED_RESET;
		end else if (in_acc && restart) begin
			gen_one_q <= seed_one_q;
			gen_two_q <= seed_two_q;
		end else if (st_q == ST_RED_A) begin
			gen_one_q <= reduced;
		end else if (st_q == ST_RED_B) begin
			gen_two_q <= reduced;
		end
	end

	// product and fold registers
	always_ff @(posedge clk) begin
		if (st_q == ST_MUL_A || st_q == ST_MUL_B) prod_q <= product;
		if (st_q == ST_MUL_B || st_q == ST_RED_A) fold_q <= folded;
	end

	// combine: z = g1 - g2, wrapped into 1..WRAP_ADD
	assign mix_diff = gen_two_q - gen_one_q;
	assign mix_val  = (gen_one_q > gen_two_q) ? (gen_one_q - gen_two_q)
	                                           : (WRAP_ADD - mix_diff);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mix_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mix_go) value_q <= mix_val;
	end

	assign out_valid    = out_valid_q;
	assign random_value = value_q;

	// checks
	a_acc_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> st_q == ST_MUL_A)
		else $error("accepted word did not start the multiply step");

	a_gen_one_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RED_A |=> gen_one_q < MOD_ONE)
		else $error("generator one not reduced below its modulus");

	a_gen_two_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RED_B |=> gen_two_q < MOD_TWO)
		else $error("generator two not reduced below its modulus");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (value_q != '0) && (value_q <= WRAP_ADD))
		else $error("output value out of range");

	a_mix_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MIX) && !out_free |=> st_q == ST_MIX)
		else $error("combine step left while output register full");

endmodule
